// ===== rtl/nmea_gga_position_parser_macros.svh =====
// Assertion macros shared by the checker
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// Check an implication on every clock edge out of reset
`define NGP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication in the next cycle
`define NGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ngp_pkg.sv =====
`default_nettype none
package ngp_pkg;

    localparam int unsigned IntCap   = 131071;
    localparam int unsigned LimitE7  = 1800000000;
    localparam int unsigned NumberCap = 31;
    // Fraction digits kept per coordinate
    localparam int unsigned FracDigits = 5;

    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChComma = 8'h2c;
    localparam logic [7:0] ChDot   = 8'h2e;
    localparam logic [7:0] ChS     = 8'h53;
    localparam logic [7:0] ChW     = 8'h57;

    // Number syntax states
    localparam logic [1:0] NumInt  = 2'd0;
    localparam logic [1:0] NumFrac = 2'd1;
    localparam logic [1:0] NumDone = 2'd2;

    // Header text "$GPGGA"
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Raw coordinate as gathered by the front part
    typedef struct packed {
        logic [16:0] int_digits;
        logic [16:0] frac_digits;
        logic [2:0]  frac_count;
        logic        short_field;
        logic        negative;
    } t_coord;

    // One finished line handed from front to back
    typedef struct packed {
        t_coord lat;
        t_coord lon;
    } t_line;

endpackage
`default_nettype wire

// ===== rtl/nmea_gga_position_parser.sv =====
// NMEA GGA position parser. Push one received byte per cycle; CR or LF closes
// a line, and a line opening with $GPGGA yields one word holding latitude and
// longitude in 1e-7 degrees (south and west negative) plus a saturation flag.
// Bytes are taken every cycle while full is low; the scanner handles one byte
// per clock, and a four-entry line queue plus a four-stage conversion pipeline
// (degree split, minute numerator, reciprocal multiply, output register)
// decouple it from pop. A line end enters the line queue and then each stage
// in turn before its result shows. Full rises only once four results wait in
// the line queue behind four held in a stalled pipeline.
`default_nettype none
module nmea_gga_position_parser #(
    parameter int LINE_BYTES      = 256,
    parameter int FIELD_BYTES     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output      logic               full,
    input  wire logic [7:0]         i_rx_byte,
    output      logic               empty,
    input  wire logic               pop,
    output      logic signed [31:0] o_latitude_e7,
    output      logic signed [31:0] o_longitude_e7,
    output      logic               o_saturated
);
    import ngp_pkg::*;

    logic  line_valid, q_full, q_empty, q_pop;
    t_line line_w, q_data;

    assign full = q_full;

    ngp_front #(
        .LINE_BYTES(LINE_BYTES), .FIELD_BYTES(FIELD_BYTES)
    ) u_front (
        .i_clk, .i_rst_n, .i_valid(push && !q_full), .i_byte(i_rx_byte),
        .o_line_valid(line_valid), .o_line(line_w)
    );

    ngp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(line_valid), .i_data(line_w), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_data)
    );

    ngp_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_line(q_data), .o_pop(q_pop),
        .o_empty(empty), .i_pop(pop), .o_lat(o_latitude_e7),
        .o_lon(o_longitude_e7), .o_sat(o_saturated)
    );

endmodule
`default_nettype wire

// ===== rtl/ngp_front.sv =====
`default_nettype none
module ngp_front #(
    parameter int LINE_BYTES      = 256,
    parameter int FIELD_BYTES     = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    output      logic          o_line_valid,
    output      ngp_pkg::t_line o_line
);
    import ngp_pkg::*;

    localparam int PosW = $clog2(LINE_BYTES);
    localparam int CntW = $clog2(FIELD_BYTES);
    localparam logic [PosW-1:0] PosMax = PosW'(LINE_BYTES - 1);
    localparam logic [CntW-1:0] CntMax = CntW'(FIELD_BYTES - 1);
    localparam logic [2:0] FracMax = 3'(FracDigits);

    logic [PosW-1:0] r_pos, n_pos;
    logic            r_hdr, n_hdr;
    logic [4:0]      r_field, n_field;
    logic            r_first, n_first;
    logic [16:0]     r_int [2], n_int [2];
    logic [16:0]     r_frac [2], n_frac [2];
    logic [2:0]      r_fcnt [2], n_fcnt [2];
    logic [1:0]      r_nst [2], n_nst [2];
    logic [CntW-1:0] r_ccnt [2], n_ccnt [2];
    logic            r_neg [2], n_neg [2];
    logic            eol, is_digit;
    logic [3:0]      dval;
    logic [20:0]     int_x10;
    logic            k_sel, coord_hit, dir_hit;

    assign eol      = (i_byte == ChLf) || (i_byte == ChCr);
    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign dval     = i_byte[3:0];
    assign k_sel    = (r_field == 5'd4) || (r_field == 5'd5);
    assign coord_hit = (r_field == 5'd2) || (r_field == 5'd4);
    assign dir_hit   = (r_field == 5'd3) || (r_field == 5'd5);
    assign int_x10  = {r_int[k_sel], 3'b000} + {2'b00, r_int[k_sel], 1'b0}
                    + {17'd0, dval};

    // Emit the finished line
    always_comb begin
        o_line_valid = i_valid && eol && r_hdr && (r_pos >= PosW'(6));
        o_line.lat.int_digits  = r_int[0];
        o_line.lat.frac_digits = r_frac[0];
        o_line.lat.frac_count  = r_fcnt[0];
        o_line.lat.short_field = r_ccnt[0] < CntW'(3);
        o_line.lat.negative    = r_neg[0];
        o_line.lon.int_digits  = r_int[1];
        o_line.lon.frac_digits = r_frac[1];
        o_line.lon.frac_count  = r_fcnt[1];
        o_line.lon.short_field = r_ccnt[1] < CntW'(3);
        o_line.lon.negative    = r_neg[1];
    end

    // Advance the line scanner
    always_comb begin
        n_pos = r_pos; n_hdr = r_hdr; n_field = r_field; n_first = r_first;
        n_int = r_int; n_frac = r_frac; n_fcnt = r_fcnt; n_nst = r_nst;
        n_ccnt = r_ccnt; n_neg = r_neg;
        if (i_valid) begin
            if (eol) begin
                n_pos = '0; n_hdr = 1'b1; n_field = '0; n_first = 1'b1;
                for (int k = 0; k < 2; k++) begin
                    n_int[k] = '0; n_frac[k] = '0; n_fcnt[k] = '0;
                    n_nst[k] = NumInt; n_ccnt[k] = '0; n_neg[k] = 1'b0;
                end
            end else if (r_pos < PosMax) begin
                if (r_pos < PosW'(6) && i_byte != header_char(r_pos[2:0])) begin
                    n_hdr = 1'b0;
                end
                n_pos = r_pos + 1'b1;
                if (i_byte == ChComma) begin
                    if (r_field < 5'(NumberCap)) begin
                        n_field = r_field + 1'b1;
                    end
                    n_first = 1'b1;
                end else begin
                    n_first = 1'b0;
                    if (coord_hit && r_ccnt[k_sel] < CntMax) begin
                        n_ccnt[k_sel] = r_ccnt[k_sel] + 1'b1;
                        case (r_nst[k_sel])
                            NumInt: begin
                                if (is_digit) begin
                                    n_int[k_sel] = (int_x10 > 21'(IntCap)) ?
                                        17'(IntCap) : int_x10[16:0];
                                end else if (i_byte == ChDot) begin
                                    n_nst[k_sel] = NumFrac;
                                end else begin
                                    n_nst[k_sel] = NumDone;
                                end
                            end
                            NumFrac: begin
                                if (is_digit) begin
                                    if (r_fcnt[k_sel] < FracMax) begin
                                        n_frac[k_sel] = 17'({r_frac[k_sel], 3'b000}
                                            + {2'b00, r_frac[k_sel], 1'b0}
                                            + {17'd0, dval});
                                        n_fcnt[k_sel] = r_fcnt[k_sel] + 1'b1;
                                    end
                                end else begin
                                    n_nst[k_sel] = NumDone;
                                end
                            end
                            default: ;
                        endcase
                    end else if (dir_hit && r_first && (i_byte == ChS || i_byte == ChW)) begin
                        n_neg[k_sel] = 1'b1;
                    end
                end
            end
        end
    end

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_hdr <= 1'b1; r_field <= '0; r_first <= 1'b1;
            for (int k = 0; k < 2; k++) begin
                r_int[k] <= '0; r_frac[k] <= '0; r_fcnt[k] <= '0;
                r_nst[k] <= NumInt; r_ccnt[k] <= '0; r_neg[k] <= 1'b0;
            end
        end else begin
            r_pos <= n_pos; r_hdr <= n_hdr; r_field <= n_field; r_first <= n_first;
            r_int <= n_int; r_frac <= n_frac; r_fcnt <= n_fcnt;
            r_nst <= n_nst; r_ccnt <= n_ccnt; r_neg <= n_neg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ngp_queue.sv =====
`default_nettype none
module ngp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ngp_pkg::t_line i_data,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_empty,
    output      ngp_pkg::t_line o_data
);
    import ngp_pkg::*;

    t_line      r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Store pushed lines
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ngp_back.sv =====
`default_nettype none
module ngp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ngp_pkg::t_line i_line,
    output      logic           o_pop,
    output      logic           o_empty,
    input  wire logic           i_pop,
    output      logic signed [31:0] o_lat,
    output      logic signed [31:0] o_lon,
    output      logic           o_sat
);
    import ngp_pkg::*;

    localparam longint Scale = 10 ** FracDigits;
    // minutes scaled to e7: num * 1e7 / (60*Scale) = num * MulC / 3
    localparam longint MulC  = (10 ** (6 - FracDigits)) / 2;
    // reciprocal of 3 with 28 fractional bits, exact for products below 2^27
    localparam int     Sh3    = 28;
    localparam longint Recip3 = ((64'd1 << Sh3) + 2) / 3;
    localparam longint MinMul = MulC * Recip3;
    // reciprocal of 100 with 24 fractional bits, exact for 17-bit integers
    localparam int     Sh100    = 24;
    localparam longint Recip100 = ((64'd1 << Sh100) + 99) / 100;

    // Stage A register: degrees and raw parts per coordinate
    logic        r_va, r_vb, r_vc;
    logic [10:0] r_deg [2];
    logic [16:0] r_ia [2];
    logic [16:0] r_fpad [2];
    logic        r_big [2], r_zero [2], r_neg [2];
    // Stage B: minutes numerator
    logic [23:0] r_num [2];
    logic [10:0] r_degb [2];
    logic        r_bigb [2], r_zerob [2], r_negb [2];
    // Stage C: quotient
    logic [31:0] r_min [2];
    logic [10:0] r_degc [2];
    logic        r_bigc [2], r_zeroc [2], r_negc [2];
    // Output register
    logic        r_ov;
    logic signed [31:0] r_olat, r_olon;
    logic        r_osat;

    logic        adv_c, adv_b, adv_a, take;
    logic [31:0] mag [2];
    logic        satk [2];
    t_coord      cin [2];

    assign cin[0] = i_line.lat;
    assign cin[1] = i_line.lon;

    // Advance when the next stage is free
    assign adv_c = !r_ov || i_pop;
    assign adv_b = !r_vc || adv_c;
    assign adv_a = !r_vb || adv_b;
    assign take  = !i_empty && (!r_va || adv_a);
    assign o_pop = take;

    // Power of ten that pads n fraction digits out to the full count
    function automatic logic [16:0] pow_fill(input logic [2:0] n);
        logic [16:0] p;
        p = 17'd1;
        for (int j = 0; j < FracDigits; j++) begin
            if (3'(j) >= n) p = 17'(p * 17'd10);
        end
        return p;
    endfunction

    // Final values
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            logic [35:0] tot;
            tot = 36'(r_degc[k]) * 36'd10000000 + 36'(r_min[k]);
            satk[k] = !r_zeroc[k] && (r_bigc[k] || tot > 36'(LimitE7));
            mag[k]  = r_zeroc[k] ? 32'd0 : (satk[k] ? 32'(LimitE7) : tot[31:0]);
            if (r_negc[k]) mag[k] = 32'd0 - mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (!r_va || adv_a) r_va <= take;
            if (adv_a) r_vb <= r_va;
            if (adv_b) r_vc <= r_vb;
            if (adv_c) r_ov <= r_vc;
        end
        // Split off degrees and pad the fraction
        if (take) begin
            for (int k = 0; k < 2; k++) begin
                r_deg[k]  <= 11'((36'(cin[k].int_digits) * 36'(Recip100)) >> Sh100);
                r_ia[k]   <= cin[k].int_digits;
                r_fpad[k] <= 17'(cin[k].frac_digits * pow_fill(cin[k].frac_count));
                r_big[k]  <= cin[k].int_digits == 17'(IntCap);
                r_zero[k] <= cin[k].short_field;
                r_neg[k]  <= cin[k].negative;
            end
        end
        // Build the minutes numerator
        if (adv_a) begin
            for (int k = 0; k < 2; k++) begin
                logic [6:0] rem;
                rem = 7'(r_ia[k] - 17'(r_deg[k]) * 17'd100);
                r_num[k]   <= 24'(rem) * 24'(Scale) + 24'(r_fpad[k]);
                r_degb[k]  <= r_deg[k]; r_bigb[k] <= r_big[k];
                r_zerob[k] <= r_zero[k]; r_negb[k] <= r_neg[k];
            end
        end
        // Scale and divide by reciprocal
        if (adv_b) begin
            for (int k = 0; k < 2; k++) begin
                r_min[k]   <= 32'((53'(r_num[k]) * 53'(MinMul)) >> Sh3);
                r_degc[k]  <= r_degb[k]; r_bigc[k] <= r_bigb[k];
                r_zeroc[k] <= r_zerob[k]; r_negc[k] <= r_negb[k];
            end
        end
        // Register result
        if (adv_c) begin
            r_olat <= mag[0];
            r_olon <= mag[1];
            r_osat <= satk[0] || satk[1];
        end
    end

    assign o_empty = !r_ov;
    assign o_lat   = r_olat;
    assign o_lon   = r_olon;
    assign o_sat   = r_osat;

endmodule
`default_nettype wire

// ===== rtl/ngp_checker.sv =====
`default_nettype none
`include "nmea_gga_position_parser_macros.svh"
module ngp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_latitude_e7,
    input wire logic [31:0] o_longitude_e7,
    input wire logic        o_saturated
);
    `NGP_ASSERT_NEXT(a_hold_lat, i_clk, i_rst_n, !empty && !pop, $stable(o_latitude_e7))
    `NGP_ASSERT_IMP(a_sat_lat, i_clk, i_rst_n, !empty && !o_saturated,
        o_latitude_e7 != 32'h80000000)
    `NGP_ASSERT_IMP(a_sat_mag, i_clk, i_rst_n, !empty && o_saturated,
        o_latitude_e7 == 32'd1800000000 || o_latitude_e7 == -32'sd1800000000 ||
        o_longitude_e7 == 32'd1800000000 || o_longitude_e7 == -32'sd1800000000)
    `NGP_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, empty)
endmodule

bind nmea_gga_position_parser ngp_checker u_ngp_checker (.*);
`default_nettype wire
